// ===== rtl/hsfw_pkg.sv =====
// Shared types, constants and colour lookup for the horizontal span word filler.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsfw_pkg;

  localparam int unsigned WORDS_PER_ROW_DEF = 64;
  localparam int unsigned SPAN_LIMIT        = 512;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned ADDR_W            = 14;
  localparam int unsigned DATA_W            = 16;
  localparam int unsigned WIDX_W            = 6;

  localparam logic [7:0] PAT_NONE = 8'h00;
  localparam logic [7:0] PAT_FULL = 8'hFF;
  localparam logic [7:0] PAT_STIP = 8'hAA;
  localparam logic [7:0] PAT_ALT  = 8'h55;

  localparam logic [3:0] COL_BLACK       = 4'd0;
  localparam logic [3:0] COL_WHITE       = 4'd1;
  localparam logic [3:0] COL_WHITE_STIP  = 4'd2;
  localparam logic [3:0] COL_GREEN       = 4'd3;
  localparam logic [3:0] COL_GREEN_STIP  = 4'd4;
  localparam logic [3:0] COL_RED         = 4'd5;
  localparam logic [3:0] COL_RED_STIP    = 4'd6;
  localparam logic [3:0] COL_YELLOW      = 4'd7;

  // One classified span, ready for the word emitter.
  typedef struct packed {
    logic [ADDR_W-1:0] row_base;
    logic [WIDX_W-1:0] first_w;
    logic [WIDX_W-1:0] last_w;
    logic [DATA_W-1:0] lead;
    logic [DATA_W-1:0] mid;
    logic [DATA_W-1:0] trail;
    logic              has_lead;
    logic              has_trail;
    logic              or_mode;
  } span_cmd_t;

  // Green mask in the high byte, red mask in the low byte.
  function automatic logic [15:0] colour_masks(logic [3:0] code);
    logic [15:0] m;
    unique case (code)
      COL_BLACK:      m = {PAT_NONE, PAT_NONE};
      COL_WHITE:      m = {PAT_FULL, PAT_FULL};
      COL_WHITE_STIP: m = {PAT_STIP, PAT_STIP};
      COL_GREEN:      m = {PAT_FULL, PAT_NONE};
      COL_GREEN_STIP: m = {PAT_STIP, PAT_NONE};
      COL_RED:        m = {PAT_NONE, PAT_FULL};
      COL_RED_STIP:   m = {PAT_NONE, PAT_STIP};
      COL_YELLOW:     m = {PAT_STIP, PAT_ALT};
      default:        m = {PAT_FULL, PAT_FULL};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hsfw_front.sv =====
// Front end: classifies a span request into bounds, word range and edge masks.
// Depends on hsfw_pkg.
`default_nettype none

module hsfw_front #(
  parameter int unsigned WORDS_PER_ROW = hsfw_pkg::WORDS_PER_ROW_DEF
) (
  input  wire logic [8:0]        pos_x,
  input  wire logic [7:0]        pos_y,
  input  wire logic [9:0]        span_length,
  input  wire logic [3:0]        colour,
  input  wire logic              pad,
  input  wire logic              or_mode,
  output hsfw_pkg::span_cmd_t    cmd,
  output logic                   nonempty
);
  import hsfw_pkg::*;

  logic [9:0]  s;
  logic [10:0] sum;
  logic [10:0] e_raw;
  logic [9:0]  e;
  logic        too_short;
  logic [5:0]  sw;
  logic [2:0]  sb;
  logic [6:0]  ew;
  logic [2:0]  eb;
  logic [2:0]  tsh;
  logic        single;
  logic [15:0] masks;
  logic [7:0]  g;
  logic [7:0]  r;
  logic [7:0]  g_t;
  logic [7:0]  r_t;
  logic [15:0] lead;
  logic [15:0] trail;
  logic [16:0] row_prod;

  always_comb begin
    masks     = colour_masks(colour);
    g         = masks[15:8];
    r         = masks[7:0];
    s         = {1'b0, pos_x} + {9'd0, pad};
    sum       = {2'b00, pos_x} + {1'b0, span_length};
    e_raw     = sum - {10'd0, pad};
    too_short = span_length <= {8'd0, pad, 1'b0};
    // clamp the end at the right edge of the row
    e         = (e_raw > 11'(SPAN_LIMIT)) ? 10'(SPAN_LIMIT) : e_raw[9:0];
    nonempty  = !too_short && (e > s);

    sw  = s[8:3];
    sb  = s[2:0];
    ew  = e[9:3];
    eb  = e[2:0];
    tsh = 3'(4'd8 - {1'b0, eb});

    g_t   = g << tsh;
    r_t   = r << tsh;
    lead  = {g >> sb, r >> sb};
    trail = (eb != 3'd0) ? {g_t, r_t} : 16'h0000;

    single = (sb != 3'd0) && (eb != 3'd0) && (sw == ew[5:0]);

    row_prod = 17'(pos_y) * 17'(WORDS_PER_ROW);

    cmd.row_base  = row_prod[ADDR_W-1:0];
    cmd.first_w   = sw;
    cmd.last_w    = (eb != 3'd0) ? ew[5:0] : 6'(ew - 7'd1);
    cmd.lead      = single ? (lead & trail) : lead;
    cmd.mid       = pad ? {1'b0, g[7:1], 1'b0, r[7:1]} : {g, r};
    cmd.trail     = trail;
    cmd.has_lead  = sb != 3'd0;
    cmd.has_trail = (eb != 3'd0) && !single;
    cmd.or_mode   = or_mode;
  end

endmodule

`default_nettype wire

// ===== rtl/hsfw_queue.sv =====
// Short command queue between the span classifier and the word emitter.
// Depends on hsfw_pkg.
`default_nettype none

module hsfw_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  hsfw_pkg::span_cmd_t      push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output logic                     q_valid,
  output hsfw_pkg::span_cmd_t      q_cmd
);
  import hsfw_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  span_cmd_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsfw_back.sv =====
// Back end: walks a span's word range; one framebuffer word a cycle unless stalled.
// Depends on hsfw_pkg.
`default_nettype none

module hsfw_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  hsfw_pkg::span_cmd_t      q_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [13:0]              word_addr,
  output logic [15:0]              word_data,
  output logic                     merge_or,
  output logic                     last
);
  import hsfw_pkg::*;

  span_cmd_t         cmd;
  logic              act_valid;
  logic [WIDX_W-1:0] cur_w;
  logic              emit;
  logic              at_end;
  logic [DATA_W-1:0] sel_data;
  logic              sel_merge;

  always_comb begin
    emit   = act_valid && (!out_valid || out_ready);
    pop    = !act_valid && q_valid;
    at_end = cur_w == cmd.last_w;
    priority if (cmd.has_lead && cur_w == cmd.first_w) begin
      sel_data  = cmd.lead;
      sel_merge = cmd.or_mode;
    end else if (cmd.has_trail && at_end) begin
      sel_data  = cmd.trail;
      sel_merge = cmd.or_mode;
    end else begin
      sel_data  = cmd.mid;
      sel_merge = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (at_end) begin
          act_valid <= 1'b0;
        end
      end
      if (pop) begin
        act_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd   <= q_cmd;
      cur_w <= q_cmd.first_w;
    end else if (emit) begin
      cur_w <= cur_w + 1'b1;
    end
    if (emit) begin
      word_addr <= cmd.row_base + ADDR_W'(cur_w);
      word_data <= sel_data;
      merge_or  <= sel_merge;
      last      <= at_end;
    end
  end

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (cur_w >= cmd.first_w) && (cur_w <= cmd.last_w))
    else $error("word index outside span range");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && (last == $past(at_end))))
    else $error("final word of span not marked");

  a_mid_overwrites: assert property (@(posedge clk) disable iff (rst)
    (emit && cur_w != cmd.first_w && cur_w != cmd.last_w) |=> !merge_or)
    else $error("middle word emitted with OR merge");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    (act_valid && !(emit && at_end)) |=> $stable(cmd))
    else $error("span command replaced while active");

endmodule

`default_nettype wire

// ===== rtl/hline_span_fill_words.sv =====
// Horizontal span filler: turns span requests into framebuffer word writes.
// Depends on hsfw_pkg, hsfw_front, hsfw_queue, hsfw_back.
//
// Input channel (in_valid/in_ready) takes one span request per transfer: start
// column, row, length, colour code, pad and OR mode. Output channel
// (out_valid/out_ready) gives the word writes of each span in ascending
// address order, with last set on the final write of the span. An empty span
// is accepted and gives no writes.
// A request enters the queue in the cycle it is accepted, then passes the
// emitter's command register and the output register before its first word.
// Throughput: the emitter's single word counter gives one word per cycle while
// out_ready does not stall it; it loads the next span from the queue only
// after the final word of the current one. A full row is 64 words.
// A two-entry queue lets requests be taken while the emitter works; in_ready
// drops when the queue is full.
// When the receiver stalls, the output register holds its word and the
// emitter waits; the queue keeps filling until full.
// Reset empties the queue and the output register; no memory to clear.
`default_nettype none

module hline_span_fill_words #(
  parameter int unsigned WORDS_PER_ROW = hsfw_pkg::WORDS_PER_ROW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [8:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [9:0]  span_length,
  input  wire logic [3:0]  colour,
  input  wire logic        pad,
  input  wire logic        or_mode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      word_addr,
  output logic [15:0]      word_data,
  output logic             merge_or,
  output logic             last
);
  import hsfw_pkg::*;

  span_cmd_t front_cmd;
  span_cmd_t q_cmd;
  logic      nonempty;
  logic      q_full;
  logic      q_valid;
  logic      push;
  logic      pop;

  assign in_ready = !q_full;
  // drop empty spans at the door
  assign push     = in_valid && in_ready && nonempty;

  hsfw_front #(
    .WORDS_PER_ROW(WORDS_PER_ROW)
  ) u_front (
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .span_length(span_length),
    .colour     (colour),
    .pad        (pad),
    .or_mode    (or_mode),
    .cmd        (front_cmd),
    .nonempty   (nonempty)
  );

  hsfw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(front_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  hsfw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_addr(word_addr),
    .word_data(word_data),
    .merge_or (merge_or),
    .last     (last)
  );

endmodule

`default_nettype wire
